### hw/rtl/tgp_pkg.sv
// Shared types, constants and coding functions for the ternary gradient pattern block.
`default_nettype none

package tgp_pkg;

    // Fixed field widths
    localparam int PIX_W   = 8;
    localparam int THR_W   = 9;
    localparam int DIM_W   = 11;
    localparam int COORD_W = 10;
    localparam int PAT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIFF_W  = 11;

    // Line store word: two rows above in the upper byte, row above in the lower byte
    localparam int LINE_W = 2 * PIX_W;

    // Geometry defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = 9'd30;
    localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd64;
    localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd128;

    // Result queue geometry
    localparam int MAX_RES  = 4;
    localparam int RES_CNT_W = 3;
    localparam int Q_DEPTH  = 8;
    localparam int Q_PTR_W  = 3;
    localparam int Q_CNT_W  = 4;

    // Sign codes (sign + 1)
    localparam logic [1:0] SIGN_NEG  = 2'd0;
    localparam logic [1:0] SIGN_ZERO = 2'd1;
    localparam logic [1:0] SIGN_POS  = 2'd2;

    // Pixel request travelling from the input stage to the coder
    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               row_ge1;
        logic               row_ge2;
        logic               col_ge1;
        logic               col_ge2;
        logic               right;
        logic               last_row;
    } item_t;

    // One coded result
    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               end_of_run;
        logic               end_of_frame;
    } result_t;

    // Ternary sign of a difference: the positive test wins
    function automatic logic [1:0] sign_code(input logic signed [DIFF_W-1:0] d,
                                             input logic [THR_W-1:0] thr);
        logic signed [DIFF_W-1:0] t;
        t = $signed({{(DIFF_W-THR_W){1'b0}}, thr});
        if (d >= t)
        begin
            return SIGN_POS;
        end
        if (d <= -t)
        begin
            return SIGN_NEG;
        end
        return SIGN_ZERO;
    endfunction

    // Pattern code (sign_x + 1) * 3 + (sign_y + 1)
    function automatic logic [PAT_W-1:0] pattern_code(input logic [1:0] sx,
                                                      input logic [1:0] sy);
        return PAT_W'({2'b00, sx} * 4'd3 + {2'b00, sy});
    endfunction

    // Signed difference of two pixels
    function automatic logic signed [DIFF_W-1:0] pix_diff(input logic [PIX_W-1:0] a,
                                                          input logic [PIX_W-1:0] b);
        return $signed({{(DIFF_W-PIX_W){1'b0}}, a}) - $signed({{(DIFF_W-PIX_W){1'b0}}, b});
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tgp_line_mem.sv
// Line store memory holding the two previous rows, with a registered read.
`default_nettype none

module tgp_line_mem #(
    parameter int DEPTH = tgp_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(tgp_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [tgp_pkg::LINE_W-1:0]  rd_data,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [tgp_pkg::LINE_W-1:0]  wr_data
);

    logic [tgp_pkg::LINE_W-1:0] mem [DEPTH];
    logic [tgp_pkg::LINE_W-1:0] rd_data_reg;

    // Write the updated column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the incoming column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/tgp_coder.sv
// Gradient sign coder: forms up to four results per pixel and the line store write-back.
`default_nettype none

module tgp_coder (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 stage_valid,
    input  wire tgp_pkg::item_t                       item,
    input  wire logic [tgp_pkg::LINE_W-1:0]           line_rd,
    input  wire logic [tgp_pkg::THR_W-1:0]            threshold,
    output logic      [tgp_pkg::RES_CNT_W-1:0]        push_cnt,
    output tgp_pkg::result_t [tgp_pkg::MAX_RES-1:0]   push_res,
    output logic      [tgp_pkg::LINE_W-1:0]           line_wr
);

    localparam int PW = tgp_pkg::PIX_W;

    logic [PW-1:0] above;
    logic [PW-1:0] two_above;

    // Pixel delay registers
    logic [PW-1:0] above_d1_reg;
    logic [PW-1:0] above_d2_reg;
    logic [PW-1:0] two_above_d1_reg;
    logic [PW-1:0] recent0_reg;
    logic [PW-1:0] recent1_reg;

    logic signed [tgp_pkg::DIFF_W-1:0] dx_main;
    logic signed [tgp_pkg::DIFF_W-1:0] dy_main;
    logic signed [tgp_pkg::DIFF_W-1:0] dy_right;
    logic signed [tgp_pkg::DIFF_W-1:0] dx_last;
    logic signed [tgp_pkg::DIFF_W-1:0] zero_diff;

    logic [tgp_pkg::COORD_W-1:0] row_m1;
    logic [tgp_pkg::COORD_W-1:0] col_m1;

    logic                                       take_above;
    logic                                       take_last;
    logic [tgp_pkg::MAX_RES-1:0]                cand_v;
    tgp_pkg::result_t [tgp_pkg::MAX_RES-1:0]    cand;

    assign two_above = line_rd[tgp_pkg::LINE_W-1:PW];
    assign above     = line_rd[PW-1:0];

    // Store the current pixel under the row above
    assign line_wr = {above, item.pixel};

    // Advance the delay line on every coded pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_d1_reg     <= '0;
            above_d2_reg     <= '0;
            two_above_d1_reg <= '0;
            recent0_reg      <= '0;
            recent1_reg      <= '0;
        end
        else if (stage_valid)
        begin
            above_d2_reg     <= above_d1_reg;
            above_d1_reg     <= above;
            two_above_d1_reg <= two_above;
            recent1_reg      <= recent0_reg;
            recent0_reg      <= item.pixel;
        end
    end

    // Central differences, zero on the border rows and columns
    assign zero_diff = '0;
    assign dx_main  = item.col_ge2 ? tgp_pkg::pix_diff(above, above_d2_reg) : zero_diff;
    assign dy_main  = item.row_ge2 ? tgp_pkg::pix_diff(recent0_reg, two_above_d1_reg)
                                   : zero_diff;
    assign dy_right = item.row_ge2 ? tgp_pkg::pix_diff(item.pixel, two_above) : zero_diff;
    assign dx_last  = item.col_ge2 ? tgp_pkg::pix_diff(item.pixel, recent1_reg) : zero_diff;

    assign row_m1 = item.row - tgp_pkg::COORD_W'(1);
    assign col_m1 = item.col - tgp_pkg::COORD_W'(1);

    assign take_above = stage_valid && item.row_ge1 && item.col_ge1;
    assign take_last  = stage_valid && item.last_row && item.col_ge1;

    // Candidate results in raster order
    always_comb
    begin
        cand_v[0] = take_above;
        cand_v[1] = take_above && item.right;
        cand_v[2] = take_last;
        cand_v[3] = take_last && item.right;

        cand[0].pattern = tgp_pkg::pattern_code(tgp_pkg::sign_code(dx_main, threshold),
                                                tgp_pkg::sign_code(dy_main, threshold));
        cand[0].row = row_m1;
        cand[0].col = col_m1;
        cand[0].end_of_frame = 1'b0;

        cand[1].pattern = tgp_pkg::pattern_code(tgp_pkg::sign_code(zero_diff, threshold),
                                                tgp_pkg::sign_code(dy_right, threshold));
        cand[1].row = row_m1;
        cand[1].col = item.col;
        cand[1].end_of_frame = 1'b0;

        cand[2].pattern = tgp_pkg::pattern_code(tgp_pkg::sign_code(dx_last, threshold),
                                                tgp_pkg::sign_code(zero_diff, threshold));
        cand[2].row = item.row;
        cand[2].col = col_m1;
        cand[2].end_of_frame = 1'b0;

        cand[3].pattern = tgp_pkg::pattern_code(tgp_pkg::sign_code(zero_diff, threshold),
                                                tgp_pkg::sign_code(zero_diff, threshold));
        cand[3].row = item.row;
        cand[3].col = item.col;
        cand[3].end_of_frame = 1'b1;

        // Mark the last result of this request
        cand[0].end_of_run = !(cand_v[1] || cand_v[2] || cand_v[3]);
        cand[1].end_of_run = !(cand_v[2] || cand_v[3]);
        cand[2].end_of_run = !cand_v[3];
        cand[3].end_of_run = 1'b1;
    end

    // Pack the valid candidates to the front
    always_comb
    begin
        logic [tgp_pkg::RES_CNT_W-1:0] pos;
        pos = '0;
        push_res = '0;
        for (int i = 0; i < tgp_pkg::MAX_RES; i++)
        begin
            if (cand_v[i])
            begin
                push_res[pos[1:0]] = cand[i];
                pos = pos + tgp_pkg::RES_CNT_W'(1);
            end
        end
        push_cnt = pos;
    end

endmodule

`default_nettype wire

### hw/rtl/tgp_res_fifo.sv
// Result queue: takes up to four results a cycle, delivers one a cycle while popped.
`default_nettype none

module tgp_res_fifo (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [tgp_pkg::RES_CNT_W-1:0]        push_cnt,
    input  wire tgp_pkg::result_t [tgp_pkg::MAX_RES-1:0] push_res,
    input  wire logic                                 pop,
    output tgp_pkg::result_t                          head,
    output logic      [tgp_pkg::Q_CNT_W-1:0]          count
);

    tgp_pkg::result_t                 entry_reg [tgp_pkg::Q_DEPTH];
    logic [tgp_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [tgp_pkg::Q_PTR_W-1:0]      wr_ptr_next;
    logic [tgp_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [tgp_pkg::Q_PTR_W-1:0]      rd_ptr_next;
    logic [tgp_pkg::Q_CNT_W-1:0]      count_reg;
    logic [tgp_pkg::Q_CNT_W-1:0]      count_next;

    // Pointer and fill level updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + tgp_pkg::Q_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + tgp_pkg::Q_PTR_W'(pop);
        count_next  = count_reg + tgp_pkg::Q_CNT_W'(push_cnt) - tgp_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the packed results into free slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tgp_pkg::MAX_RES; i++)
        begin
            if (tgp_pkg::RES_CNT_W'(i) < push_cnt)
            begin
                entry_reg[tgp_pkg::Q_PTR_W'(wr_ptr_reg + tgp_pkg::Q_PTR_W'(i))] <= push_res[i];
            end
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

### hw/rtl/ternary_gradient_pattern_top.sv
// Top level of the ternary gradient pattern coder.
`default_nettype none

// Takes one 8-bit grey pixel per clock in raster order and returns, for each pixel, a
// pattern code 0..8 from the signs of its horizontal and vertical central differences
// (reflect-101 borders). Pixel (r-1, c-1) is coded when pixel (r, c) arrives; the last
// column and the last row add extra results, so one pixel gives 0 to 4 results. Input
// takes one pixel per cycle while the 8-entry result queue has room; output delivers
// one result per cycle while out_stall is low, so the sustained input rate is set by
// the result count: one pixel per cycle over most of the frame (the queue absorbs the
// two results of a right-column pixel), half the output rate along the last row. The
// line store is read when a pixel is taken and its coded results enter the queue in
// the cycle after. The line stores need no clearing after reset. Writing image_width
// or image_height restarts the frame at row 0, col 0.
module ternary_gradient_pattern_top #(
    parameter int MAX_WIDTH  = tgp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tgp_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [tgp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tgp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [tgp_pkg::PIX_W-1:0]         pixel,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [tgp_pkg::PAT_W-1:0]         pattern,
    output logic      [tgp_pkg::COORD_W-1:0]       row,
    output logic      [tgp_pkg::COORD_W-1:0]       col,
    output logic                                   end_of_run,
    output logic                                   end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Configuration registers
    logic [tgp_pkg::THR_W-1:0] threshold_reg;
    logic [tgp_pkg::DIM_W-1:0] width_reg;
    logic [tgp_pkg::DIM_W-1:0] height_reg;

    // Position of the next pixel
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;
    logic          at_right;
    logic          at_last_row;
    logic          accept;
    logic          geom_write;

    // Coding stage
    logic             stage_valid_reg;
    tgp_pkg::item_t   stage_item_reg;
    tgp_pkg::item_t   item_in;
    logic [CW-1:0]    stage_addr_reg;

    logic [tgp_pkg::LINE_W-1:0]                    line_rd;
    logic [tgp_pkg::LINE_W-1:0]                    line_wr;
    logic [tgp_pkg::RES_CNT_W-1:0]                 push_cnt;
    tgp_pkg::result_t [tgp_pkg::MAX_RES-1:0]       push_res;
    tgp_pkg::result_t                              head;
    logic [tgp_pkg::Q_CNT_W-1:0]                   q_count;
    logic                                          pop;

    // Clamp the geometry to [2, MAX]
    always_comb
    begin
        if (width_reg < tgp_pkg::DIM_W'(2))
        begin
            col_last = CW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            col_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = CW'(width_reg - tgp_pkg::DIM_W'(1));
        end

        if (height_reg < tgp_pkg::DIM_W'(2))
        begin
            row_last = RW'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            row_last = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_last = RW'(height_reg - tgp_pkg::DIM_W'(1));
        end
    end

    assign at_right    = (col_reg == col_last);
    assign at_last_row = (row_reg == row_last);

    // Hold input while the queue may not fit this and the staged request
    assign in_stall = (5'(q_count) + 5'(push_cnt)) >
                      5'(tgp_pkg::Q_DEPTH - tgp_pkg::MAX_RES);
    assign accept   = in_valid && !in_stall;

    assign geom_write = cfg_write &&
                        (cfg_index == tgp_pkg::REG_WIDTH || cfg_index == tgp_pkg::REG_HEIGHT);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tgp_pkg::THRESHOLD_RST;
            width_reg     <= tgp_pkg::WIDTH_RST;
            height_reg    <= tgp_pkg::HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tgp_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[tgp_pkg::THR_W-1:0];
                tgp_pkg::REG_WIDTH:     width_reg     <= cfg_data;
                tgp_pkg::REG_HEIGHT:    height_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Advance the raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (at_right)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Build the request for the coding stage
    always_comb
    begin
        item_in.pixel    = pixel;
        item_in.row      = tgp_pkg::COORD_W'(row_reg);
        item_in.col      = tgp_pkg::COORD_W'(col_reg);
        item_in.row_ge1  = (row_reg != '0);
        item_in.row_ge2  = (row_reg > RW'(1));
        item_in.col_ge1  = (col_reg != '0);
        item_in.col_ge2  = (col_reg > CW'(1));
        item_in.right    = at_right;
        item_in.last_row = at_last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= item_in;
            stage_addr_reg <= col_reg;
        end
    end

    tgp_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (line_rd),
        .wr_en   (stage_valid_reg),
        .wr_addr (stage_addr_reg),
        .wr_data (line_wr)
    );

    tgp_coder u_coder (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid_reg),
        .item        (stage_item_reg),
        .line_rd     (line_rd),
        .threshold   (threshold_reg),
        .push_cnt    (push_cnt),
        .push_res    (push_res),
        .line_wr     (line_wr)
    );

    assign out_valid = (q_count != '0);
    assign pop       = out_valid && !out_stall;

    tgp_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_res (push_res),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    assign pattern      = head.pattern;
    assign row          = head.row;
    assign col          = head.col;
    assign end_of_run   = head.end_of_run;
    assign end_of_frame = head.end_of_frame;

endmodule

`default_nettype wire

### hw/rtl/tgp_checker.sv
// Port-level checker for the ternary gradient pattern top level, with its bind.
`default_nettype none

module tgp_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [tgp_pkg::PAT_W-1:0]         pattern,
    input wire logic [tgp_pkg::COORD_W-1:0]       row,
    input wire logic [tgp_pkg::COORD_W-1:0]       col,
    input wire logic                              end_of_run,
    input wire logic                              end_of_frame
);

    // Pattern code stays within the nine sign combinations
    a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pattern <= tgp_pkg::PAT_W'(8))
        else $error("pattern code above 8");

    // Frame end closes the run of its request
    a_eof_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_run)
        else $error("end_of_frame without end_of_run");

    // Frame end lies in the last row and column, never on row or column zero
    a_eof_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> row != '0 && col != '0)
        else $error("end_of_frame on a border origin");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pattern) && $stable(row)
                                   && $stable(col) && $stable(end_of_run))
        else $error("stalled result changed");

endmodule

bind ternary_gradient_pattern_top tgp_checker u_tgp_checker (.*);

`default_nettype wire

### dv/tgp_pattern_checker.sv
// Checker for the ternary gradient pattern coder: predicts every code and compares results.
module tgp_pattern_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [tgp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [tgp_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic [tgp_pkg::PIX_W-1:0]               pixel,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic [tgp_pkg::PAT_W-1:0]               pattern,
    input  logic [tgp_pkg::COORD_W-1:0]             row,
    input  logic [tgp_pkg::COORD_W-1:0]             col,
    input  logic                                    end_of_run,
    input  logic                                    end_of_frame,
    output int                                      failures,
    output int                                      outstanding
);

    localparam int LINE_DEPTH  = tgp_pkg::MAX_WIDTH_DEF;
    localparam int ROW_LIMIT   = tgp_pkg::MAX_HEIGHT_DEF;
    localparam int MAX_REPORTS = 40;

    // Shadow copy of the registers and of the coder's state
    bit [tgp_pkg::THR_W-1:0] threshold;
    bit [tgp_pkg::DIM_W-1:0] width_reg;
    bit [tgp_pkg::DIM_W-1:0] height_reg;
    bit [tgp_pkg::PIX_W-1:0] above_line [LINE_DEPTH];
    bit [tgp_pkg::PIX_W-1:0] two_above_line [LINE_DEPTH];
    bit [tgp_pkg::PIX_W-1:0] left1;
    bit [tgp_pkg::PIX_W-1:0] left2;
    bit [tgp_pkg::PIX_W-1:0] above_c1;
    bit [tgp_pkg::PIX_W-1:0] above_c2;
    bit [tgp_pkg::PIX_W-1:0] two_above_c1;
    int unsigned             next_row;
    int unsigned             next_col;
    tgp_pkg::result_t        expected_codes [$];
    int                      fail_count;

    function automatic int unsigned clamp_dim(input bit [tgp_pkg::DIM_W-1:0] v,
                                              input int unsigned most);
        if (v < 2) return 2;
        if (v > most) return most;
        return int'(v);
    endfunction

    // Positive test first, so a zero threshold turns a flat spot positive
    function automatic bit [1:0] ternary_sign(input int diff);
        if (diff >= int'(threshold)) return tgp_pkg::SIGN_POS;
        if (diff <= -int'(threshold)) return tgp_pkg::SIGN_NEG;
        return tgp_pkg::SIGN_ZERO;
    endfunction

    function automatic tgp_pkg::result_t code_at(input int dx, input int dy,
                                                 input int unsigned r, input int unsigned c,
                                                 input bit last_of_frame);
        tgp_pkg::result_t res;
        res.pattern      = tgp_pkg::PAT_W'(ternary_sign(dx) * 3 + ternary_sign(dy));
        res.row          = tgp_pkg::COORD_W'(r);
        res.col          = tgp_pkg::COORD_W'(c);
        res.end_of_run   = 1'b0;
        res.end_of_frame = last_of_frame;
        return res;
    endfunction

    // Work out the codes caused by one pixel request and advance the shadow state
    task automatic predict_pixel(input bit [tgp_pkg::PIX_W-1:0] p);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        int               a;
        int               d;
        int               pv;
        bit               right_edge;
        bit               bottom_row;
        tgp_pkg::result_t batch [tgp_pkg::MAX_RES];
        int               nb;
        w = clamp_dim(width_reg, LINE_DEPTH);
        h = clamp_dim(height_reg, ROW_LIMIT);
        r = next_row;
        c = next_col;
        pv = p;
        nb = 0;
        right_edge = (c == w - 1);
        bottom_row = (r == h - 1);
        a = above_line[c];
        d = two_above_line[c];
        // code the pixel up and to the left, and the right column of the row above
        if (r >= 1 && c >= 1)
        begin
            batch[nb] = code_at(c >= 2 ? a - int'(above_c2) : 0,
                                r >= 2 ? int'(left1) - int'(two_above_c1) : 0,
                                r - 1, c - 1, 1'b0);
            nb++;
            if (right_edge)
            begin
                batch[nb] = code_at(0, r >= 2 ? pv - d : 0, r - 1, c, 1'b0);
                nb++;
            end
        end
        // the bottom row is coded as soon as the right-hand neighbor arrives
        if (bottom_row && c >= 1)
        begin
            batch[nb] = code_at(c >= 2 ? pv - int'(left2) : 0, 0, r, c - 1, 1'b0);
            nb++;
            if (right_edge)
            begin
                batch[nb] = code_at(0, 0, r, c, 1'b1);
                nb++;
            end
        end
        if (nb > 0)
        begin
            batch[nb - 1].end_of_run = 1'b1;
        end
        for (int k = 0; k < nb; k++)
        begin
            expected_codes.insert(expected_codes.size(), batch[k]);
        end
        // shift the windows and store the rows
        two_above_line[c] = tgp_pkg::PIX_W'(a);
        above_line[c]     = p;
        above_c2          = above_c1;
        above_c1          = tgp_pkg::PIX_W'(a);
        two_above_c1      = tgp_pkg::PIX_W'(d);
        left2             = left1;
        left1             = p;
        if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
        end
    endtask

    function automatic bit field_bad(input string name, input tgp_pkg::result_t want,
                                     input int unsigned got_value,
                                     input int unsigned want_value);
        if (want_value == got_value) return 1'b0;
        if (fail_count < MAX_REPORTS)
        begin
            $display("%0t: %s of code at row %0d col %0d: expected %0d, actual %0d",
                     $time, name, want.row, want.col, want_value, got_value);
        end
        return 1'b1;
    endfunction

    // Track register writes, predict on each pixel request, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        tgp_pkg::result_t want;
        bit               bad;
        if (!rst_n)
        begin
            threshold    = tgp_pkg::THRESHOLD_RST;
            width_reg    = tgp_pkg::WIDTH_RST;
            height_reg   = tgp_pkg::HEIGHT_RST;
            next_row     = 0;
            next_col     = 0;
            left1        = '0;
            left2        = '0;
            above_c1     = '0;
            above_c2     = '0;
            two_above_c1 = '0;
            expected_codes.delete();
            fail_count   = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    tgp_pkg::REG_THRESHOLD: threshold = cfg_data[tgp_pkg::THR_W-1:0];
                    tgp_pkg::REG_WIDTH:
                    begin
                        width_reg = cfg_data;
                        next_row  = 0;
                        next_col  = 0;
                    end
                    tgp_pkg::REG_HEIGHT:
                    begin
                        height_reg = cfg_data;
                        next_row   = 0;
                        next_col   = 0;
                    end
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_pixel(pixel);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_codes.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                    begin
                        $display("%0t: unexpected result: expected none, actual row %0d col %0d",
                                 $time, row, col);
                    end
                    fail_count++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    bad  = field_bad("pattern", want, pattern, want.pattern);
                    bad |= field_bad("row", want, row, want.row);
                    bad |= field_bad("col", want, col, want.col);
                    bad |= field_bad("end_of_run", want, end_of_run, want.end_of_run);
                    bad |= field_bad("end_of_frame", want, end_of_frame, want.end_of_frame);
                    if (bad)
                    begin
                        fail_count++;
                    end
                end
            end
            failures    <= fail_count;
            outstanding <= expected_codes.size();
        end
    end

endmodule

### dv/testbench.sv
// Top of the ternary gradient pattern testbench: clock, reset, stimulus and verdict.
module testbench;

    localparam logic [tgp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 12;
    localparam int BIG_PIXELS    = 8;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [tgp_pkg::CFG_IDX_W-1:0]  cfg_index = tgp_pkg::REG_THRESHOLD;
    logic [tgp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic [tgp_pkg::PIX_W-1:0]      pixel     = '0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    logic [tgp_pkg::PAT_W-1:0]      pattern;
    logic [tgp_pkg::COORD_W-1:0]    row;
    logic [tgp_pkg::COORD_W-1:0]    col;
    logic                           end_of_run;
    logic                           end_of_frame;

    int failures;
    int outstanding;
    int pixels_sent   = 0;
    int codes_checked = 0;
    int settings_used = 0;
    int gap_pct       = 29;
    int stall_pct     = 75;
    int level         = 128;

    ternary_gradient_pattern_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pattern      (pattern),
        .row          (row),
        .col          (col),
        .end_of_run   (end_of_run),
        .end_of_frame (end_of_frame)
    );

    tgp_pattern_checker pattern_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pattern      (pattern),
        .row          (row),
        .col          (col),
        .end_of_run   (end_of_run),
        .end_of_frame (end_of_frame),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one pixel request, idling first at random, and hold it until taken
    task automatic send_pixel(input logic [tgp_pkg::PIX_W-1:0] v);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= v;
        do @(posedge clk); while (in_stall);
        pixels_sent++;
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [tgp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tgp_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Hold off new requests until every pending code has come out, then settle
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Watchdog: give up after a long stretch with no handshake on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                codes_checked++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int                        ph;
        int                        i;
        int                        n;
        int                        mode;
        int                        kind;
        int                        pause_at;
        bit                        big;
        bit [tgp_pkg::THR_W-1:0]   thr;
        bit [tgp_pkg::DIM_W-1:0]   w;
        bit [tgp_pkg::DIM_W-1:0]   h;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Checkerboard at the reset threshold: each central difference spans two equal pixels, so every code is flat
        write_reg(tgp_pkg::REG_WIDTH, 11'd3);
        write_reg(tgp_pkg::REG_HEIGHT, 11'd3);
        cfg_write <= 1'b0;
        for (i = 0; i < 9; i++)
        begin
            send_pixel(i[0] ? 8'd255 : 8'd0);
        end
        drain_results();

        // Flat 2x2 frame from undersized geometry; zero threshold makes flat spots positive
        write_reg(tgp_pkg::REG_THRESHOLD, 11'd0);
        write_reg(tgp_pkg::REG_WIDTH, 11'd1);
        write_reg(tgp_pkg::REG_HEIGHT, 11'd0);
        cfg_write <= 1'b0;
        repeat (4) send_pixel(8'd77);
        drain_results();

        // Threshold above the pixel range flattens every code; unused index is ignored
        write_reg(tgp_pkg::REG_THRESHOLD, 11'd300);
        write_reg(tgp_pkg::REG_WIDTH, 11'd3);
        write_reg(tgp_pkg::REG_HEIGHT, 11'd3);
        write_reg(REG_UNUSED, 11'h7FF);
        cfg_write <= 1'b0;
        for (i = 0; i < 9; i++)
        begin
            send_pixel(i[0] ? 8'd0 : 8'd255);
        end
        drain_results();
        settings_used = 3;

        // Random phases: small frames under each idling mode, then two settings at the geometry limits
        for (ph = 0; ph < RANDOM_PHASES + 2; ph++)
        begin
            big  = (ph >= RANDOM_PHASES);
            mode = big ? 2 : ph * 3 / RANDOM_PHASES;
            gap_pct    = (mode == 0) ? 29 : (mode == 1) ? 75 : 0;
            stall_pct <= (mode == 0) ? 75 : (mode == 1) ? 29 : 0;

            case ($urandom_range(7))
                0: thr = 9'd0;
                1: thr = 9'd255;
                2: thr = 9'd256;
                3: thr = 9'd511;
                default: thr = tgp_pkg::THR_W'($urandom_range(1, 60));
            endcase
            if (big)
            begin
                thr = tgp_pkg::THR_W'($urandom_range(4, 24));
            end
            write_reg(tgp_pkg::REG_THRESHOLD, {2'($urandom_range(3)), thr});

            // Rewrite geometry most of the time, which also restarts the frame
            if (big || ph == 0 || $urandom_range(3) != 0)
            begin
                if (ph == RANDOM_PHASES)
                begin
                    w = 11'd2047;
                    h = 11'd1;
                end
                else if (big)
                begin
                    w = 11'd0;
                    h = 11'd1024;
                end
                else
                begin
                    w = ($urandom_range(5) == 0) ? tgp_pkg::DIM_W'($urandom_range(1))
                                                 : tgp_pkg::DIM_W'($urandom_range(2, 7));
                    h = ($urandom_range(5) == 0) ? tgp_pkg::DIM_W'($urandom_range(1))
                                                 : tgp_pkg::DIM_W'($urandom_range(2, 5));
                end
                write_reg(tgp_pkg::REG_WIDTH, w);
                write_reg(tgp_pkg::REG_HEIGHT, h);
            end
            cfg_write <= 1'b0;
            settings_used++;

            n        = big ? BIG_PIXELS : $urandom_range(8, 14);
            kind     = big ? 1 : $urandom_range(2);
            pause_at = (ph % 3 == 1) ? n / 2 : -1;
            for (i = 0; i < n; i++)
            begin
                if (i == pause_at)
                begin
                    drain_results();
                end
                case (kind)
                    0: send_pixel(tgp_pkg::PIX_W'($urandom_range(255)));
                    1:
                    begin
                        level = level + int'($urandom_range(48)) - 24;
                        if (level < 0) level = 0;
                        if (level > 255) level = 255;
                        send_pixel(tgp_pkg::PIX_W'(level));
                    end
                    default: send_pixel($urandom_range(1) ? 8'd255 : 8'd0);
                endcase
            end
            drain_results();
        end

        $display("Summary: %0d pixels sent under %0d register settings, %0d results compared",
                 pixels_sent, settings_used, codes_checked);
        $display("Summary: undersized and oversize geometry, zero and large thresholds, %s",
                 "mid-stream drains and both idling mixes");
        if (failures == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
